// File: rtl/core/mr_pkg.sv
`timescale 1ns / 1ps

package mr_pkg;

  // item field widths on the stream ports
  localparam int CAND_W      = 64;
  localparam int BASE_W      = 64;
  localparam int IN_TDATA_W  = CAND_W + BASE_W;
  localparam int OUT_TDATA_W = 8;

  // status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

// File: rtl/core/mr_mulmod.sv
`timescale 1ns / 1ps

module mr_mulmod #(
  parameter int W = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [W-1:0]     x,
  input  logic [W-1:0]     y,
  input  logic [W-1:0]     m,
  output mr_pkg::mm_stat_t stat,
  output logic [W-1:0]     result
);

  localparam int IW = $clog2(W);

  logic [W-1:0]  x_r, y_r, m_r, acc_r;
  logic [W-1:0]  x_nxt, y_nxt, m_nxt, acc_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          ph_r, ph_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;

  // one modular add: (p + q) mod m for p, q < m
  logic [W-1:0] add_q, gap, sum;
  assign add_q = ph_r ? x_r : acc_r;
  assign gap   = m_r - add_q;
  assign sum   = (acc_r >= gap) ? (acc_r - gap) : (acc_r + add_q);

  // double-then-add over the multiplier bits, msb first
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    idx_nxt  = idx_r;
    ph_nxt   = ph_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt   = x;
      y_nxt   = y;
      m_nxt   = m;
      acc_nxt = '0;
      idx_nxt = IW'(W - 1);
      ph_nxt  = 1'b0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      acc_nxt = sum;
      if (!ph_r && y_r[idx_r]) begin
        ph_nxt = 1'b1;
      end else begin
        ph_nxt = 1'b0;
        if (idx_r == '0) begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      ph_r   <= ph_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
    idx_r <= idx_nxt;
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign result    = acc_r;

endmodule

// File: rtl/core/miller_rabin_round.sv
`timescale 1ns / 1ps
// One Miller-Rabin round on candidate n with witness base a.
// Input channel in_*: one item carries n and a; the block answers with one
// result item on out_*: bit 0 of out_tdata is 1 when n passes the round.
// Only the low NUM_WIDTH bits of each input field are used.
// Small and even candidates are decided at once.
// Other candidates go through one shared serial modular multiplier: one
// product takes, per multiplier bit, one double and, for each set bit, one
// add, one step per cycle. A round first strips the power of two out of
// n-1, then spends one product to reduce a mod n, up to about 2W products
// for a^d mod n and up to W-2 squarings after; the multiplier's bit-serial
// loop sets the length of a round.
// in_tready is high only while no item is in work: one item at a time.
// The result waits in an output register; if the receiver stalls, the
// next item is still taken and held at its end until the register frees.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_tvalid.
module miller_rabin_round #(
  parameter int NUM_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [63:0] candidate, [127:64] witness_base
  input  logic [mr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] probably_prime, [7:1] zero
  output logic [mr_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int NW = NUM_WIDTH;
  localparam int SW = $clog2(NUM_WIDTH);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_STRIP   = 4'd1;
  localparam logic [3:0] ST_RED     = 4'd2;
  localparam logic [3:0] ST_POW_CHK = 4'd3;
  localparam logic [3:0] ST_POW_MUL = 4'd4;
  localparam logic [3:0] ST_POW_SQ  = 4'd5;
  localparam logic [3:0] ST_CHK1    = 4'd6;
  localparam logic [3:0] ST_SQ_LOOP = 4'd7;
  localparam logic [3:0] ST_SQ_CHK  = 4'd8;
  localparam logic [3:0] ST_FIN     = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] a_r, a_nxt;
  logic [NW-1:0] d_r, d_nxt;
  logic [NW-1:0] acc_r, acc_nxt;
  logic [NW-1:0] base_r, base_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic          res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_bit_r, out_bit_nxt;

  logic              mm_start;
  logic [NW-1:0]     mm_x, mm_y, mm_res;
  mr_pkg::mm_stat_t  mm_st;

  logic [NW-1:0] in_n, in_a, nm1;
  logic          in_acc;

  assign in_n   = in_tdata[NW-1:0];
  assign in_a   = in_tdata[mr_pkg::CAND_W +: NW];
  assign nm1    = {n_r[NW-1:1], 1'b0};
  assign in_acc = in_tvalid && in_tready;

  // shared modular multiplier, modulus is always n
  mr_mulmod #(
    .W (NW)
  ) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .m      (n_r),
    .stat   (mm_st),
    .result (mm_res)
  );

  // round sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    a_nxt     = a_r;
    d_nxt     = d_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    s_nxt     = s_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    mm_start  = 1'b0;
    mm_x      = acc_r;
    mm_y      = base_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          n_nxt = in_n;
          a_nxt = in_a;
          d_nxt = {in_n[NW-1:1], 1'b0};
          s_nxt = '0;
          if (in_n <= NW'(1) || in_n == NW'(4)) begin
            res_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else if (in_n <= NW'(3)) begin
            res_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else if (!in_n[0]) begin
            res_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_STRIP;
          end
        end
      end
      // pull factors of two out of n-1
      ST_STRIP: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + 1'b1;
        end else begin
          cnt_nxt   = s_r - 1'b1;
          mm_start  = 1'b1;
          mm_x      = NW'(1);
          mm_y      = a_r;
          state_nxt = ST_RED;
        end
      end
      // a mod n as 1 * a mod n
      ST_RED: begin
        if (mm_st.done) begin
          if (mm_res == '0) begin
            res_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            base_nxt  = mm_res;
            acc_nxt   = NW'(1);
            state_nxt = ST_POW_CHK;
          end
        end
      end
      // square-and-multiply over the bits of d, lsb first
      ST_POW_CHK: begin
        if (d_r == '0) begin
          state_nxt = ST_CHK1;
        end else if (d_r[0]) begin
          mm_start  = 1'b1;
          state_nxt = ST_POW_MUL;
        end else begin
          mm_start  = 1'b1;
          mm_x      = base_r;
          state_nxt = ST_POW_SQ;
        end
      end
      ST_POW_MUL: begin
        if (mm_st.done) begin
          acc_nxt = mm_res;
          if (d_r[NW-1:1] == '0) begin
            d_nxt     = '0;
            state_nxt = ST_POW_CHK;
          end else begin
            mm_start  = 1'b1;
            mm_x      = base_r;
            state_nxt = ST_POW_SQ;
          end
        end
      end
      ST_POW_SQ: begin
        if (mm_st.done) begin
          base_nxt  = mm_res;
          d_nxt     = d_r >> 1;
          state_nxt = ST_POW_CHK;
        end
      end
      // first look at x = a^d
      ST_CHK1: begin
        if (acc_r == NW'(1) || acc_r == nm1) begin
          res_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else if (cnt_r == '0) begin
          res_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          mm_start  = 1'b1;
          mm_y      = acc_r;
          state_nxt = ST_SQ_LOOP;
        end
      end
      // repeated squaring, watching for n-1 or 1
      ST_SQ_LOOP: begin
        if (mm_st.done) begin
          acc_nxt   = mm_res;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = ST_SQ_CHK;
        end
      end
      ST_SQ_CHK: begin
        if (acc_r == nm1) begin
          res_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else if (acc_r == NW'(1) || cnt_r == '0) begin
          res_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          mm_start  = 1'b1;
          mm_y      = acc_r;
          state_nxt = ST_SQ_LOOP;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_bit_nxt   = out_bit_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_FIN && (!out_valid_r || out_tready)) begin
      out_valid_nxt = 1'b1;
      out_bit_nxt   = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r       <= n_nxt;
    a_r       <= a_nxt;
    d_r       <= d_nxt;
    acc_r     <= acc_nxt;
    base_r    <= base_nxt;
    s_r       <= s_nxt;
    cnt_r     <= cnt_nxt;
    res_r     <= res_nxt;
    out_bit_r <= out_bit_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(mr_pkg::OUT_TDATA_W - 1)'(0), out_bit_r};

  // multiplier is never restarted while it works
  a_mm_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mm_start |-> !mm_st.busy)
    else $error("multiplier started while busy");

  // a finished product is only seen in a state that waits for one
  a_mm_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mm_st.done |-> (state_r == ST_RED || state_r == ST_POW_MUL ||
                    state_r == ST_POW_SQ || state_r == ST_SQ_LOOP))
    else $error("product finished outside a wait state");

  // an accepted item closes the input until its round ends
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input open right after an item");

  // a new result only comes from the final state
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the final state");

endmodule

// File: dv/tb_miller_rabin_round.sv
`timescale 1ns / 1ps

module tb_miller_rabin_round;

  localparam int NUM_W = 64;
  localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - NUM_W);
  localparam int N_DIR = 22;
  localparam int N_RAND = 80;
  localparam int PHASE_LEN = 20;
  // watchdog limit on cycles with no handshake, well above a full-width round
  localparam int QUIET_LIMIT = 150000;

  typedef struct packed {
    logic [63:0] cand;
    logic [63:0] base;
    logic        typed;
    logic        verdict;
  } round_row_t;

  typedef struct packed {
    logic [63:0] cand;
    logic [63:0] base;
    logic        verdict;
  } verdict_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [mr_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [mr_pkg::OUT_TDATA_W-1:0] out_tdata;

  int         snd_idle_pct = 0;
  int         rcv_stall_pct = 0;
  int         fail_cnt = 0;
  int         quiet_cycles = 0;
  verdict_t   pending_verdicts[$];
  verdict_t   oldest;
  round_row_t dir_rows [N_DIR];

  miller_rabin_round #(.NUM_WIDTH(NUM_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // exact modular product through a 128-bit intermediate
  function automatic logic [63:0] mod_mul(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, x} * {64'd0, y};
    prod = prod % {64'd0, m};
    return prod[63:0];
  endfunction

  function automatic logic [63:0] mod_pow(input logic [63:0] b, input logic [63:0] e,
                                          input logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1;
    while (e != 64'd0) begin
      if (e[0]) acc = mod_mul(acc, b, m);
      b = mod_mul(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // pass/fail of one round for candidate n and base a
  function automatic logic mr_verdict(input logic [63:0] cand, input logic [63:0] base);
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] nm1;
    logic [63:0] d;
    logic [63:0] x;
    int          s;
    n = cand & WORD_MASK;
    a = base & WORD_MASK;
    if (n <= 64'd1 || n == 64'd4) return 1'b0;
    if (n <= 64'd3) return 1'b1;
    if (!n[0]) return 1'b0;
    a = a % n;
    if (a == 64'd0) return 1'b1;
    nm1 = n - 64'd1;
    d = nm1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    x = mod_pow(a, d, n);
    if (x == 64'd1 || x == nm1) return 1'b1;
    for (int k = 1; k < s; k++) begin
      x = mod_mul(x, x, n);
      if (x == nm1) return 1'b1;
      if (x == 64'd1) return 1'b0;
    end
    return 1'b0;
  endfunction

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result item, out_tdata=%0h", $time, out_tdata);
        fail_cnt++;
      end else begin
        oldest = pending_verdicts.pop_front();
        if (out_tdata !== {{(mr_pkg::OUT_TDATA_W-1){1'b0}}, oldest.verdict}) begin
          $display("%0t: n=%0h a=%0h probably_prime expected %0b, actual out_tdata %0h",
                   $time, oldest.cand, oldest.base, oldest.verdict, out_tdata);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // send one item, then log its verdict once it is taken
  task automatic push_round(input logic [63:0] cand, input logic [63:0] base,
                            input logic typed, input logic verdict);
    verdict_t v;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {base, cand};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    v.cand = cand;
    v.base = base;
    v.verdict = typed ? verdict : mr_verdict(cand, base);
    pending_verdicts.push_back(v);
  endtask

  // hold off until every outstanding result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] cand;
    logic [63:0] base;
    int          pick;
    // cand, base, verdict typed in, verdict
    dir_rows = '{
      '{64'd0, 64'd5, 1'b1, 1'b0},
      '{64'd1, 64'd0, 1'b1, 1'b0},
      '{64'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1},
      '{64'd3, 64'd0, 1'b1, 1'b1},
      '{64'd4, 64'd3, 1'b1, 1'b0},
      '{64'd6, 64'd5, 1'b1, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0001, 1'b1, 1'b0},
      '{64'd5, 64'd0, 1'b1, 1'b1},
      '{64'd7, 64'd14, 1'b1, 1'b1},
      '{64'd65537, 64'd3, 1'b1, 1'b1},
      // largest 64-bit prime
      '{64'hFFFF_FFFF_FFFF_FFC5, 64'd2, 1'b1, 1'b1},
      '{64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1},
      '{64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC4, 1'b1, 1'b1},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 1'b0, 1'b0},
      '{64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555, 1'b0, 1'b0},
      // strong pseudoprimes, carmichael numbers and other odd composites
      '{64'd2047, 64'd2, 1'b0, 1'b0},
      '{64'd2047, 64'd3, 1'b0, 1'b0},
      '{64'd561, 64'd2, 1'b0, 1'b0},
      '{64'd341, 64'd2, 1'b0, 1'b0},
      '{64'd25, 64'd7, 1'b0, 1'b0},
      '{64'd9, 64'd8, 1'b0, 1'b0},
      '{64'd3215031751, 64'd2, 1'b0, 1'b0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items, no idling
    foreach (dir_rows[i]) begin
      push_round(dir_rows[i].cand, dir_rows[i].base, dir_rows[i].typed, dir_rows[i].verdict);
    end
    drain_results();

    // random items in four idling phases
    for (int i = 0; i < N_RAND; i++) begin
      if (i % PHASE_LEN == 0) begin
        if (i > 0) drain_results();
        case (i / PHASE_LEN)
          0: begin
            snd_idle_pct = 0;
            rcv_stall_pct <= 0;
          end
          1: begin
            snd_idle_pct = 88;
            rcv_stall_pct <= 0;
          end
          2: begin
            snd_idle_pct = 0;
            rcv_stall_pct <= 88;
          end
          default: begin
            snd_idle_pct = 27;
            rcv_stall_pct <= 27;
          end
        endcase
      end
      pick = $urandom_range(0, 99);
      base = {$urandom, $urandom};
      if (pick < 8) begin
        // full-width odd candidate, slow
        cand = {$urandom, $urandom} | 64'd1;
      end else if (pick < 11) begin
        cand = {32'd0, $urandom_range(0, 16)};
      end else if (pick < 14) begin
        cand = {$urandom, $urandom} & ~64'd1;
      end else if (pick < 22) begin
        // base a multiple of n
        cand = {32'd0, $urandom_range(5, 65535)} | 64'd1;
        base = cand * {32'd0, $urandom};
      end else if (pick < 40) begin
        case ($urandom_range(0, 7))
          0: cand = 64'd2047;
          1: cand = 64'd1373653;
          2: cand = 64'd561;
          3: cand = 64'd1105;
          4: cand = 64'd1729;
          5: cand = 64'd65537;
          6: cand = 64'd7919;
          default: cand = 64'd25326001;
        endcase
      end else begin
        cand = {32'd0, $urandom_range(5, 65535)} | 64'd1;
      end
      push_round(cand, base, 1'b0, 1'b0);
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
